>>> sv/rkck_pkg.sv
package rkck_pkg;

  typedef logic [0:15][7:0] blk_t;
  typedef logic [0:10][0:15][7:0] rkey_t;
  typedef logic [0:255][7:0] sbox_t;

  localparam sbox_t SBOX = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam blk_t CIPHER_KEY = {
    8'h86,8'h9F,8'h77,8'h45,8'hC1,8'h3F,8'hD8,8'h90,
    8'hCC,8'hF2,8'h91,8'h88,8'hE3,8'hCC,8'h3E,8'hDF
  };
  localparam logic [0:15][3:0] PERM = {
    4'hC,4'h3,4'h6,4'h4,4'h1,4'hB,4'hF,4'h8,4'h2,4'h7,4'h0,4'h5,4'hA,4'hE,4'hD,4'h9
  };
  localparam blk_t XOR_VEC = {
    8'hA9,8'h3E,8'h1F,8'hD6,8'h7C,8'h55,8'hA3,8'h29,
    8'hB7,8'h5F,8'hDD,8'hA6,8'h2A,8'h95,8'hC7,8'hA5
  };
  localparam blk_t SUB_VEC = {
    8'h67,8'hD4,8'h5D,8'hA3,8'h29,8'h6D,8'h00,8'h6A,
    8'h4E,8'h7C,8'h53,8'h7B,8'hF5,8'h53,8'h8C,8'h74
  };
  localparam logic [0:9][7:0] RCON = {
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic sbox_t make_inv_sbox();
    sbox_t inv;
    inv = '0;
    for (int i = 0; i < 256; i++) begin
      inv[SBOX[i]] = i[7:0];
    end
    return inv;
  endfunction

  function automatic rkey_t make_round_keys();
    logic [0:175][7:0] w;
    logic [7:0] t0, t1, t2, t3, tmp;
    rkey_t rk;
    w = '0;
    for (int i = 0; i < 16; i++) w[i] = CIPHER_KEY[i];
    for (int i = 4; i < 44; i++) begin
      t0 = w[(i-1)*4];
      t1 = w[(i-1)*4+1];
      t2 = w[(i-1)*4+2];
      t3 = w[(i-1)*4+3];
      if ((i % 4) == 0) begin
        tmp = t0;
        t0 = SBOX[t1] ^ RCON[i/4-1];
        t1 = SBOX[t2];
        t2 = SBOX[t3];
        t3 = SBOX[tmp];
      end
      w[i*4]   = w[(i-4)*4]   ^ t0;
      w[i*4+1] = w[(i-4)*4+1] ^ t1;
      w[i*4+2] = w[(i-4)*4+2] ^ t2;
      w[i*4+3] = w[(i-4)*4+3] ^ t3;
    end
    for (int r = 0; r < 11; r++)
      for (int j = 0; j < 16; j++) rk[r][j] = w[r*16+j];
    return rk;
  endfunction

  localparam sbox_t INV_SBOX   = make_inv_sbox();
  localparam rkey_t ROUND_KEYS = make_round_keys();

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    return a8 ^ a;
  endfunction

  function automatic logic [7:0] mul11(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    return a8 ^ a2 ^ a;
  endfunction

  function automatic logic [7:0] mul13(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    return a8 ^ a4 ^ a;
  endfunction

  function automatic logic [7:0] mul14(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    return a8 ^ a4 ^ a2;
  endfunction

endpackage

>>> sv/rkck_if.sv
interface rkck_rec_if;
  logic        valid;
  logic        ready;
  logic [63:0] record_hi;
  logic [63:0] record_lo;
  modport source (output valid, output record_hi, output record_lo, input ready);
  modport sink   (input valid, input record_hi, input record_lo, output ready);
endinterface

interface rkck_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] derived_hi;
  logic [63:0] derived_lo;
  modport source (output valid, output derived_hi, output derived_lo, input ready);
  modport sink   (input valid, input derived_hi, input derived_lo, output ready);
endinterface

>>> sv/rkck_aes_stage.sv
module rkck_aes_stage
  import rkck_pkg::*;
#(
  parameter int ROUND = 9
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  blk_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output blk_t out_data_o
);

  blk_t s, t, u, res;
  logic valid_q;
  blk_t data_q;

  always_comb begin
    // the last cipher round also takes the initial key addition
    s = (ROUND == 9) ? (in_data_i ^ ROUND_KEYS[10]) : in_data_i;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[c*4+r] = INV_SBOX[s[((c - r + 4) % 4)*4 + r]];
    u = t ^ ROUND_KEYS[ROUND];
    res = u;
    if (ROUND != 0) begin
      for (int c = 0; c < 4; c++) begin
        res[c*4]   = mul14(u[c*4]) ^ mul11(u[c*4+1]) ^ mul13(u[c*4+2]) ^ mul9(u[c*4+3]);
        res[c*4+1] = mul9(u[c*4])  ^ mul14(u[c*4+1]) ^ mul11(u[c*4+2]) ^ mul13(u[c*4+3]);
        res[c*4+2] = mul13(u[c*4]) ^ mul9(u[c*4+1])  ^ mul14(u[c*4+2]) ^ mul11(u[c*4+3]);
        res[c*4+3] = mul11(u[c*4]) ^ mul13(u[c*4+1]) ^ mul9(u[c*4+2])  ^ mul14(u[c*4+3]);
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= res;
    end
  end

endmodule

>>> sv/rkck_mix_stage.sv
module rkck_mix_stage
  import rkck_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  blk_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output blk_t out_data_o
);

  blk_t x, y, res;
  logic [127:0] minuend, subtrahend, diff;
  logic valid_q;
  blk_t data_q;

  always_comb begin
    x = in_data_i ^ XOR_VEC;
    // downward chain reads only bytes not yet updated, so all taps are parallel
    y = x;
    for (int i = 1; i < 16; i++) y[PERM[i]] = x[PERM[i]] ^ x[PERM[i-1]];
    // borrow chain in permuted order is one wide subtraction
    for (int j = 0; j < 16; j++) begin
      minuend[j*8 +: 8]    = y[PERM[j]];
      subtrahend[j*8 +: 8] = SUB_VEC[PERM[j]];
    end
    diff = minuend - subtrahend;
    res = y;
    for (int j = 0; j < 16; j++) res[PERM[j]] = diff[j*8 +: 8];
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= res;
    end
  end

endmodule

>>> sv/rap_key_to_content_key.sv
// throughput: one record per cycle while key_o.ready is high; each of the ten
// inverse cipher rounds and each mixing round has its own register stage,
// the last one is the output register, and a stall holds every stage that
// has a waiting successor
// reset clears only the stage valid bits; the stage data registers are not reset
module rap_key_to_content_key
  import rkck_pkg::*;
#(
  parameter int MIX_ROUNDS = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  rkck_rec_if.sink   rec_i,
  rkck_key_if.source key_o
);

  localparam int NSTAGE = 10 + MIX_ROUNDS;

  logic [NSTAGE:0] valid;
  logic [NSTAGE:0] ready;
  blk_t            data [NSTAGE+1];

  assign valid[0]    = rec_i.valid;
  assign rec_i.ready = ready[0];
  assign data[0]     = {rec_i.record_hi, rec_i.record_lo};

  for (genvar g = 0; g < 10; g++) begin : g_aes
    rkck_aes_stage #(.ROUND(9 - g)) u_aes (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[g]),
      .in_ready_o  (ready[g]),
      .in_data_i   (data[g]),
      .out_valid_o (valid[g+1]),
      .out_ready_i (ready[g+1]),
      .out_data_o  (data[g+1])
    );
  end

  for (genvar g = 10; g < NSTAGE; g++) begin : g_mix
    rkck_mix_stage u_mix (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[g]),
      .in_ready_o  (ready[g]),
      .in_data_i   (data[g]),
      .out_valid_o (valid[g+1]),
      .out_ready_i (ready[g+1]),
      .out_data_o  (data[g+1])
    );
  end

  assign ready[NSTAGE]    = key_o.ready;
  assign key_o.valid      = valid[NSTAGE];
  assign key_o.derived_hi = data[NSTAGE][0:7];
  assign key_o.derived_lo = data[NSTAGE][8:15];

endmodule
